// ===== hdl/lzd_pkg.sv =====
package lzd_pkg;

    localparam int HISTORY_DEPTH = 4096;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int LEN_W         = 24;
    localparam int CNT_W         = 5;
    localparam int MIN_MATCH     = 3;

    localparam logic [7:0]         MAGIC_BYTE  = 8'h10;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST = 24'd512;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_FINISHED  = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_BAD_DIST  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FLAGS,
        PH_ITEM,
        PH_TOKEN_LO,
        PH_DONE,
        PH_FAULT
    } t_phase;

    // Engine state: taking input, copying a match, or sending the finished result.
    typedef enum logic [1:0] {
        E_IN,
        E_COPY,
        E_FIN
    } t_eng;

    typedef struct packed {
        t_status    status;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } t_mem_req;

endpackage

// ===== hdl/lz77_stream_decompressor.sv =====
// Channel   Direction  tdata            tuser           tlast
// s_axis    in         data_byte [7:0]  start_req [0]   -
// m_axis    out        out_byte [7:0]   status [2:0]    last
// cfg       in         max_length [23:0] (i_cfg_valid / o_cfg_ready)
//
// A header, flag or literal byte is taken as it arrives, and a literal gives its result in the same cycle.
// A match token is taken one byte per cycle and then copied one byte per cycle while the result buffer has room; the
// history memory has one read and one write port, so each copy cycle writes one byte and reads the next.
// A stream that ends on a data byte sends the finished result as a separate result after it.
// Reset is synchronous and active low; the history memory is not cleared.
// A stalled m_axis fills a two-entry result buffer and then holds the decoder.
module lz77_stream_decompressor
    import lzd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic             s_axis_tuser,   // [0] start_req
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]       m_axis_tuser,   // [2:0] status
    output logic             m_axis_tlast,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0] r_max_len;
    logic             push_ok;
    t_push            push;
    t_mem_req         mem;
    logic [7:0]       rdata;
    t_result          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    lzd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_len  (r_max_len),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_start    (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_push_ok  (push_ok),
        .o_push     (push),
        .o_mem      (mem),
        .i_rdata    (rdata)
    );

    lzd_ram #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (8)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    lzd_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_push_ok (push_ok),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

endmodule

// ===== hdl/lzd_ram.sv =====
module lzd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lzd_obuf.sv =====
module lzd_obuf
    import lzd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_push_ok,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);

    t_result    r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    assign push      = i_push.valid;
    assign pop       = o_valid && i_ready;
    assign o_valid   = (r_count != 2'd0);
    assign o_push_ok = (r_count != 2'd2);
    assign o_res     = r_buf[r_rd];

    always_comb begin
        n_wr    = push ? ~r_wr : r_wr;
        n_rd    = pop ? ~r_rd : r_rd;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= i_push.res;
        end
    end

endmodule

// ===== hdl/lzd_core.sv =====
module lzd_core
    import lzd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LEN_W-1:0] i_max_len,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_start,
    input  logic [7:0]       i_byte,
    input  logic             i_push_ok,
    output t_push            o_push,
    output t_mem_req         o_mem,
    input  logic [7:0]       i_rdata
);

    t_eng               r_eng,      n_eng;
    t_phase             r_phase,    n_phase;
    logic [1:0]         r_hdr_cnt,  n_hdr_cnt;
    logic [7:0]         r_flags,    n_flags;
    logic [2:0]         r_bit_pos,  n_bit_pos;
    logic [LEN_W-1:0]   r_target,   n_target;
    logic [LEN_W-1:0]   r_produced, n_produced;
    logic [7:0]         r_tok_hi,   n_tok_hi;
    logic [HIST_AW-1:0] r_wp,       n_wp;
    logic [HIST_AW-1:0] r_dist_n,   n_dist_n;
    logic [CNT_W-1:0]   r_cnt,      n_cnt;
    logic               r_fwd,      n_fwd;
    logic [7:0]         r_fwd_data, n_fwd_data;

    logic               in_fire;
    logic [LEN_W-1:0]   hdr_len;
    logic [HIST_AW-1:0] tok_d;
    logic               dist_ok;
    logic               cur_bit;
    logic [LEN_W-1:0]   prod_inc;
    logic               hit_end;
    logic [7:0]         copy_data;
    logic               copy_end;
    logic [HIST_AW-1:0] next_raddr;
    logic               is_magic;
    logic               hdr_last;

    assign in_fire    = (r_eng == E_IN) && i_push_ok && i_in_valid;
    assign hdr_len    = {i_byte, r_target[15:0]};
    assign tok_d      = {r_tok_hi[3:0], i_byte};
    // distance = tok_d + 1 must not exceed the bytes produced so far.
    assign dist_ok    = r_produced > {{(LEN_W-HIST_AW){1'b0}}, tok_d};
    assign cur_bit    = r_flags[3'd7 - r_bit_pos];
    assign prod_inc   = r_produced + 24'd1;
    assign hit_end    = (prod_inc == r_target);
    assign copy_data  = r_fwd ? r_fwd_data : i_rdata;
    assign copy_end   = hit_end || (r_cnt == 5'd1);
    // r_dist_n is the inverted distance field, so wp + r_dist_n = wp - distance.
    assign next_raddr = r_wp + 12'd1 + r_dist_n;
    assign is_magic   = (i_byte == MAGIC_BYTE);
    assign hdr_last   = (r_hdr_cnt == 2'd3);

    // Next state
    always_comb begin
        n_eng      = r_eng;
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_flags    = r_flags;
        n_bit_pos  = r_bit_pos;
        n_target   = r_target;
        n_produced = r_produced;
        n_tok_hi   = r_tok_hi;
        n_wp       = r_wp;
        n_dist_n   = r_dist_n;
        n_cnt      = r_cnt;
        n_fwd      = r_fwd;
        n_fwd_data = r_fwd_data;
        case (r_eng)
            E_IN: begin
                if (in_fire) begin
                    if (i_start) begin
                        n_flags    = 8'd0;
                        n_bit_pos  = 3'd0;
                        n_target   = '0;
                        n_produced = '0;
                        n_tok_hi   = 8'd0;
                        n_wp       = '0;
                        if (is_magic) begin
                            n_hdr_cnt = 2'd1;
                            n_phase   = PH_HEADER;
                        end else begin
                            n_hdr_cnt = 2'd0;
                            n_phase   = PH_FAULT;
                        end
                    end else begin
                        case (r_phase)
                            PH_HEADER: begin
                                case (r_hdr_cnt)
                                    2'd2: begin
                                        n_target[15:8] = i_byte;
                                        n_hdr_cnt      = 2'd3;
                                    end
                                    2'd3: begin
                                        n_target  = hdr_len;
                                        n_hdr_cnt = 2'd0;
                                        n_bit_pos = 3'd0;
                                        if (hdr_len > i_max_len) begin
                                            n_phase = PH_FAULT;
                                        end else if (hdr_len == '0) begin
                                            n_phase = PH_DONE;
                                        end else begin
                                            n_phase = PH_FLAGS;
                                        end
                                    end
                                    default: begin
                                        n_target[7:0] = i_byte;
                                        n_hdr_cnt     = 2'd2;
                                    end
                                endcase
                            end
                            PH_FLAGS: begin
                                n_flags   = i_byte;
                                n_bit_pos = 3'd0;
                                n_phase   = PH_ITEM;
                            end
                            PH_ITEM: begin
                                if (cur_bit) begin
                                    n_tok_hi = i_byte;
                                    n_phase  = PH_TOKEN_LO;
                                end else begin
                                    n_wp       = r_wp + 12'd1;
                                    n_produced = prod_inc;
                                    if (hit_end) begin
                                        n_phase = PH_DONE;
                                        n_eng   = E_FIN;
                                    end else if (r_bit_pos == 3'd7) begin
                                        n_phase = PH_FLAGS;
                                    end else begin
                                        n_bit_pos = r_bit_pos + 3'd1;
                                    end
                                end
                            end
                            PH_TOKEN_LO: begin
                                if (!dist_ok) begin
                                    n_phase = PH_FAULT;
                                end else begin
                                    n_dist_n = ~tok_d;
                                    n_cnt    = {1'b0, r_tok_hi[7:4]} + CNT_W'(MIN_MATCH);
                                    n_fwd    = 1'b0;
                                    n_eng    = E_COPY;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            E_COPY: begin
                if (i_push_ok) begin
                    n_wp       = r_wp + 12'd1;
                    n_produced = prod_inc;
                    n_cnt      = r_cnt - 5'd1;
                    if (copy_end) begin
                        if (hit_end) begin
                            n_phase = PH_DONE;
                            n_eng   = E_FIN;
                        end else begin
                            n_eng = E_IN;
                            if (r_bit_pos == 3'd7) begin
                                n_phase = PH_FLAGS;
                            end else begin
                                n_bit_pos = r_bit_pos + 3'd1;
                                n_phase   = PH_ITEM;
                            end
                        end
                    end else begin
                        // Distance one reads the entry written in this same cycle.
                        n_fwd      = (next_raddr == r_wp);
                        n_fwd_data = copy_data;
                    end
                end
            end
            E_FIN: begin
                if (i_push_ok) begin
                    n_eng = E_IN;
                end
            end
            default: begin
                n_eng = E_IN;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready        = (r_eng == E_IN) && i_push_ok;
        o_push            = '0;
        o_push.res.status = ST_DATA;
        o_mem             = '0;
        case (r_eng)
            E_IN: begin
                if (in_fire) begin
                    if (i_start) begin
                        if (!is_magic) begin
                            o_push.valid      = 1'b1;
                            o_push.res.status = ST_BAD_MAGIC;
                            o_push.res.last   = 1'b1;
                        end
                    end else begin
                        case (r_phase)
                            PH_HEADER: begin
                                if (hdr_last && (hdr_len > i_max_len)) begin
                                    o_push.valid      = 1'b1;
                                    o_push.res.status = ST_TOO_LONG;
                                    o_push.res.last   = 1'b1;
                                end else if (hdr_last && (hdr_len == '0)) begin
                                    o_push.valid      = 1'b1;
                                    o_push.res.status = ST_FINISHED;
                                    o_push.res.last   = 1'b1;
                                end
                            end
                            PH_ITEM: begin
                                if (!cur_bit) begin
                                    o_push.valid      = 1'b1;
                                    o_push.res.status = ST_DATA;
                                    o_push.res.data   = i_byte;
                                    o_push.res.last   = !hit_end;
                                    o_mem.we          = 1'b1;
                                    o_mem.waddr       = r_wp;
                                    o_mem.wdata       = i_byte;
                                end
                            end
                            PH_TOKEN_LO: begin
                                if (!dist_ok) begin
                                    o_push.valid      = 1'b1;
                                    o_push.res.status = ST_BAD_DIST;
                                    o_push.res.last   = 1'b1;
                                end else begin
                                    o_mem.re    = 1'b1;
                                    o_mem.raddr = r_wp + ~tok_d;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            E_COPY: begin
                if (i_push_ok) begin
                    o_push.valid      = 1'b1;
                    o_push.res.status = ST_DATA;
                    o_push.res.data   = copy_data;
                    o_push.res.last   = copy_end && !hit_end;
                    o_mem.we          = 1'b1;
                    o_mem.waddr       = r_wp;
                    o_mem.wdata       = copy_data;
                    o_mem.re          = !copy_end;
                    o_mem.raddr       = next_raddr;
                end
            end
            E_FIN: begin
                if (i_push_ok) begin
                    o_push.valid      = 1'b1;
                    o_push.res.status = ST_FINISHED;
                    o_push.res.last   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng      <= E_IN;
            r_phase    <= PH_IDLE;
            r_hdr_cnt  <= 2'd0;
            r_flags    <= 8'd0;
            r_bit_pos  <= 3'd0;
            r_target   <= '0;
            r_produced <= '0;
            r_tok_hi   <= 8'd0;
            r_wp       <= '0;
            r_cnt      <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_eng      <= n_eng;
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_flags    <= n_flags;
            r_bit_pos  <= n_bit_pos;
            r_target   <= n_target;
            r_produced <= n_produced;
            r_tok_hi   <= n_tok_hi;
            r_wp       <= n_wp;
            r_cnt      <= n_cnt;
            r_fwd      <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist_n   <= n_dist_n;
        r_fwd_data <= n_fwd_data;
    end

endmodule

// ===== hdl/lzd_checker.sv =====
module lzd_checker
    import lzd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [7:0]       m_axis_tdata,
    input logic [2:0]       m_axis_tuser,
    input logic             m_axis_tlast
);

    // The result buffer is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Every status other than a data byte carries a zero byte and ends its request.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_DATA)) |-> (m_axis_tdata == 8'd0 && m_axis_tlast))
        else $error("status result with data or without last");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_BAD_DIST))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind lz77_stream_decompressor lzd_checker u_lzd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_lz77_stream_decompressor.sv =====
`timescale 1ns / 1ps

module tb_lz77_stream_decompressor;
    import lzd_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } t_stream_byte;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       typed;
        t_result    want;
    } t_dir_row;

    localparam t_result NO_RESULT = '{ST_DATA, 8'h00, 1'b0};

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [7:0]       m_axis_tdata;
    logic [2:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [LEN_W-1:0] i_cfg_data;

    // Decoder state as the testbench tracks it.
    logic [LEN_W-1:0]   max_len_cfg;
    t_phase             dec_phase;
    logic [1:0]         dec_hdr_cnt;
    logic [7:0]         dec_flags;
    logic [3:0]         dec_bit_pos;
    logic [LEN_W-1:0]   dec_target;
    logic [LEN_W-1:0]   dec_produced;
    logic [7:0]         dec_tok_hi;
    logic [7:0]         dec_hist [HISTORY_DEPTH];
    logic [HIST_AW-1:0] dec_wptr;

    t_result      step_out [20];
    int           step_n;
    t_result      decoded_q [$];
    t_stream_byte stim_q [$];

    bit send_gaps_on;
    bit recv_stall_on;
    bit hold_req;
    int mismatches;
    int quiet_cycles;

    lz77_stream_decompressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 30) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    task automatic add_result(input t_status st, input logic [7:0] b);
        step_out[step_n] = '{st, b, 1'b0};
        step_n++;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        dec_hist[dec_wptr] = b;
        dec_wptr = dec_wptr + 1'b1;
        dec_produced = dec_produced + 1'b1;
        add_result(ST_DATA, b);
    endtask

    task automatic check_end();
        if (dec_produced == dec_target) begin
            add_result(ST_FINISHED, 8'h00);
            dec_phase = PH_DONE;
        end
    endtask

    task automatic next_bit();
        dec_bit_pos = dec_bit_pos + 1'b1;
        if (dec_bit_pos >= 4'd8) begin
            dec_bit_pos = 4'd8;
            dec_phase = PH_FLAGS;
        end else begin
            dec_phase = PH_ITEM;
        end
    endtask

    // Works out the results that one compressed byte causes.
    task automatic decode_byte(input logic start, input logic [7:0] b);
        int                 k;
        int                 copies;
        logic [15:0]        tok;
        logic [12:0]        dist_val;
        logic [HIST_AW-1:0] rd_addr;
        step_n = 0;
        if (start) begin
            dec_hdr_cnt = 2'd0;
            dec_flags = 8'h00;
            dec_bit_pos = 4'd8;
            dec_target = '0;
            dec_produced = '0;
            dec_tok_hi = 8'h00;
            dec_wptr = '0;
            if (b != MAGIC_BYTE) begin
                add_result(ST_BAD_MAGIC, 8'h00);
                dec_phase = PH_FAULT;
            end else begin
                dec_hdr_cnt = 2'd1;
                dec_phase = PH_HEADER;
            end
        end else begin
            case (dec_phase)
                PH_HEADER: begin
                    k = (dec_hdr_cnt == 2'd0) ? 1 : dec_hdr_cnt;
                    dec_target = dec_target | ({16'd0, b} << (8 * (k - 1)));
                    if (k >= 3) begin
                        dec_hdr_cnt = 2'd0;
                        if (dec_target > max_len_cfg) begin
                            add_result(ST_TOO_LONG, 8'h00);
                            dec_phase = PH_FAULT;
                        end else begin
                            dec_phase = PH_FLAGS;
                            dec_bit_pos = 4'd8;
                            check_end();
                        end
                    end else begin
                        dec_hdr_cnt = 2'(k + 1);
                    end
                end
                PH_FLAGS: begin
                    dec_flags = b;
                    dec_bit_pos = 4'd0;
                    dec_phase = PH_ITEM;
                end
                PH_ITEM: begin
                    if (dec_flags[7 - dec_bit_pos[2:0]]) begin
                        dec_tok_hi = b;
                        dec_phase = PH_TOKEN_LO;
                    end else begin
                        emit_byte(b);
                        next_bit();
                        check_end();
                    end
                end
                PH_TOKEN_LO: begin
                    tok = {dec_tok_hi, b};
                    copies = tok[15:12] + MIN_MATCH;
                    dist_val = {1'b0, tok[11:0]} + 13'd1;
                    if (dist_val > dec_produced) begin
                        add_result(ST_BAD_DIST, 8'h00);
                        dec_phase = PH_FAULT;
                    end else begin
                        // A match stops early once the header length is reached.
                        while (copies > 0 && dec_produced != dec_target) begin
                            rd_addr = dec_wptr - dist_val[HIST_AW-1:0];
                            emit_byte(dec_hist[rd_addr]);
                            copies--;
                        end
                        next_bit();
                        check_end();
                    end
                end
                default: begin
                end
            endcase
        end
        if (step_n > 0) begin
            step_out[step_n - 1].last = 1'b1;
        end
    endtask

    // Offers one request after a random gap and records what it should produce.
    task automatic send_item(input logic start, input logic [7:0] b, input logic typed,
                             input t_result want);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        decode_byte(start, b);
        if (typed) begin
            decoded_q.push_back(want);
        end else begin
            for (int i = 0; i < step_n; i++) begin
                decoded_q.push_back(step_out[i]);
            end
        end
    endtask

    task automatic play_stim();
        t_stream_byte sb;
        while (stim_q.size() > 0) begin
            sb = stim_q.pop_front();
            send_item(sb.start, sb.data, 1'b0, NO_RESULT);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        max_len_cfg = value;
    endtask

    // Builds a compressed stream of len bytes, with bad distances when corrupt is set; cut > 0 stops it early.
    // With far set, matches are long and, once enough bytes are made, one of them reaches the full history depth.
    task automatic build_stream(input int unsigned len, input int tok_pct, input bit corrupt,
                                input int cut, input bit far);
        t_stream_byte body [$];
        t_stream_byte grp [$];
        int unsigned  made;
        int unsigned  dmax;
        int unsigned  d;
        int unsigned  span;
        int           limit;
        bit           reach;
        logic [7:0]   flags;
        logic [7:0]   rb;
        logic [3:0]   nib;
        logic [11:0]  dm1;
        limit = (cut > 0) ? cut : 32'h3fff_ffff;
        reach = far;
        body.push_back('{1'b1, MAGIC_BYTE});
        body.push_back('{1'b0, len[7:0]});
        body.push_back('{1'b0, len[15:8]});
        body.push_back('{1'b0, len[23:16]});
        made = 0;
        while (made < len && body.size() < limit) begin
            flags = 8'($urandom_range(0, 255));
            grp.delete();
            for (int i = 0; i < 8 && made < len; i++) begin
                if (made > 0 && $urandom_range(0, 99) < tok_pct) begin
                    flags[7 - i] = 1'b1;
                    nib = far ? 4'hF : 4'($urandom_range(0, 15));
                    dmax = (made > HISTORY_DEPTH) ? HISTORY_DEPTH : made;
                    d = $urandom_range(1, dmax);
                    if (reach && made >= HISTORY_DEPTH) begin
                        d = HISTORY_DEPTH;
                        reach = 1'b0;
                    end else if (corrupt && made < HISTORY_DEPTH && $urandom_range(0, 3) == 0) begin
                        d = made + 1;
                    end
                    dm1 = 12'(d - 1);
                    grp.push_back('{1'b0, {nib, dm1[11:8]}});
                    grp.push_back('{1'b0, dm1[7:0]});
                    span = nib + MIN_MATCH;
                    made += (span < len - made) ? span : len - made;
                end else begin
                    flags[7 - i] = 1'b0;
                    rb = 8'($urandom_range(0, 255));
                    grp.push_back('{1'b0, rb});
                    made++;
                end
            end
            body.push_back('{1'b0, flags});
            foreach (grp[j]) body.push_back(grp[j]);
        end
        // Bytes after the end of a stream should be ignored.
        if (cut == 0) begin
            repeat ($urandom_range(0, 2)) begin
                rb = 8'($urandom_range(0, 255));
                body.push_back('{1'b0, rb});
            end
        end
        for (int j = 0; j < body.size() && j < limit; j++) begin
            stim_q.push_back(body[j]);
        end
    endtask

    task automatic random_phase(input int budget);
        int               done_items;
        int               kind;
        int               cap;
        int unsigned      len;
        longint unsigned  over;
        logic             st;
        logic [7:0]       rb;
        done_items = 0;
        while (done_items < budget) begin
            send_gaps_on  = ($urandom_range(0, 3) != 0);
            recv_stall_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            cap = (max_len_cfg > 40) ? 40 : max_len_cfg;
            if (kind < 55 && cap > 0) begin
                build_stream($urandom_range(1, cap), $urandom_range(20, 70),
                             $urandom_range(0, 7) == 0, 0, 1'b0);
            end else if (kind < 68 && cap > 0) begin
                build_stream($urandom_range(1, cap), 50, 1'b0, $urandom_range(2, 12), 1'b0);
            end else if (kind < 80 && max_len_cfg != {LEN_W{1'b1}}) begin
                over = $urandom_range(1, 64);
                len = 32'((max_len_cfg + over > 24'hFF_FFFF) ? 24'hFF_FFFF
                                                             : max_len_cfg + over);
                if ($urandom_range(0, 3) == 0) begin
                    len = 24'hFF_FFFF;
                end
                build_stream(len, 0, 1'b0, 4, 1'b0);
            end else if (kind < 88) begin
                build_stream(0, 0, 1'b0, 0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    st = ($urandom_range(0, 4) == 0);
                    rb = 8'($urandom_range(0, 255));
                    stim_q.push_back('{st, rb});
                end
            end
            done_items += stim_q.size();
            play_stim();
        end
    endtask

    // Receiver: a random stall before every result, and one long hold-off on request.
    initial begin : result_sink
        int pause;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pause = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                pause = recv_stall_on ? $urandom_range(0, 6) : 0;
            end
            if (pause > 0) begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d byte %02h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tuser !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tuser, want.status));
                end
                if (m_axis_tdata !== want.data) begin
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              m_axis_tdata, want.data));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_axis_tlast, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run
        t_dir_row dir_rows [26];
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        mismatches = 0;
        hold_req = 1'b0;
        send_gaps_on = 1'b1;
        recv_stall_on = 1'b1;
        max_len_cfg = MAX_LEN_RST;
        dec_phase = PH_IDLE;
        dec_hdr_cnt = 2'd0;
        dec_flags = 8'h00;
        dec_bit_pos = 4'd8;
        dec_target = '0;
        dec_produced = '0;
        dec_tok_hi = 8'h00;
        dec_wptr = '0;

        // Idle byte, bad magic, empty stream, length just over the limit,
        // a literal followed by the longest match, and a match with nothing behind it.
        dir_rows = '{
            '{1'b0, 8'h55, 1'b0, NO_RESULT},
            '{1'b1, 8'h11, 1'b1, '{ST_BAD_MAGIC, 8'h00, 1'b1}},
            '{1'b1, 8'h10, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b1, '{ST_FINISHED, 8'h00, 1'b1}},
            '{1'b1, 8'h10, 1'b0, NO_RESULT},
            '{1'b0, 8'h01, 1'b0, NO_RESULT},
            '{1'b0, 8'h02, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b1, '{ST_TOO_LONG, 8'h00, 1'b1}},
            '{1'b1, 8'h10, 1'b0, NO_RESULT},
            '{1'b0, 8'h13, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'h40, 1'b0, NO_RESULT},
            '{1'b0, 8'hFF, 1'b1, '{ST_DATA, 8'hFF, 1'b1}},
            '{1'b0, 8'hF0, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'hAB, 1'b0, NO_RESULT},
            '{1'b1, 8'h10, 1'b0, NO_RESULT},
            '{1'b0, 8'h04, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'h80, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b0, NO_RESULT},
            '{1'b0, 8'h00, 1'b1, '{ST_BAD_DIST, 8'h00, 1'b1}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < 26; r++) begin
            send_item(dir_rows[r].start, dir_rows[r].data, dir_rows[r].typed, dir_rows[r].want);
        end

        // The sink holds off while requests keep coming, so the block has to stall its input.
        send_gaps_on = 1'b0;
        hold_req = 1'b1;
        build_stream(40, 60, 1'b0, 0, 1'b0);
        play_stim();
        random_phase(50);

        drain_results();
        write_max_length('0);
        random_phase(30);

        drain_results();
        write_max_length({LEN_W{1'b1}});
        random_phase(40);

        drain_results();
        write_max_length(LEN_W'($urandom_range(16, 100)));
        random_phase(50);

        drain_results();
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
